### hdl/i2a_pkg.sv
// Shared types, constants and helpers for the integer to decimal ASCII core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

   localparam int VALUE_BITS_DEF = 32;

   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;

   // decimal digits of 2^(bits-1); 1233/4096 ~ log10(2), exact for bits up to 64
   function automatic int dec_digits(input int bits);
      return (((bits - 1) * 1233) >> 12) + 1;
   endfunction

   // handoff from the converter to the character emitter
   typedef struct packed {
      logic valid;
      logic negative;
   } conv_ctl_type;

endpackage

`default_nettype wire

### hdl/i2a_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on i2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2a_conv
   import i2a_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int DIGITS     = dec_digits(VALUE_BITS_DEF)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [VALUE_BITS-1:0]  req_value,
   output conv_ctl_type                       out_ctl,
   input  wire logic                          out_ready,
   output logic [DIGITS*4-1:0]                out_bcd
);

   localparam int CNT_W = $clog2(VALUE_BITS);

   typedef enum logic [2:0] {
      CV_IDLE = 3'b001,
      CV_RUN  = 3'b010,
      CV_DONE = 3'b100
   } conv_state_type;

   conv_state_type          state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [DIGITS*4-1:0]     bcd_ff, bcd_in;
   logic [DIGITS*4-1:0]     adj;
   logic                    neg_ff, neg_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]   raw;

   always_comb begin
      raw = req_value;
      // add 3 to every digit of 5 or more before the doubling shift
      for (int i = 0; i < DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                      : bcd_ff[i*4 +: 4];
      end

      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;

      unique case (state_ff)
         CV_IDLE: begin
            if (req_valid) begin
               neg_in   = raw[VALUE_BITS-1];
               // most negative value negates to itself, read as unsigned it is exact
               mag_in   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS - 1);
               state_in = CV_RUN;
            end
         end
         CV_RUN: begin
            bcd_in = {adj[DIGITS*4-2:0], mag_ff[VALUE_BITS-1]};
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = CV_DONE;
            end
         end
         CV_DONE: begin
            if (out_ready) begin
               state_in = CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign req_ready = (state_ff == CV_IDLE);
   assign out_ctl   = '{valid: (state_ff == CV_DONE), negative: neg_ff};
   assign out_bcd   = bcd_ff;

`ifndef SYNTHESIS
   a_accept_starts_run : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == CV_RUN && cnt_ff == CNT_W'(VALUE_BITS - 1)))
      else $error("conversion did not start after accept");

   a_run_ends_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == CV_RUN && cnt_ff == '0) |=> (state_ff == CV_DONE))
      else $error("conversion did not finish after last bit");

   a_done_holds : assert property (@(posedge clock) disable iff (reset)
      (out_ctl.valid && !out_ready) |=> (out_ctl.valid && $stable(out_bcd)))
      else $error("BCD result dropped before handoff");
`endif

endmodule

`default_nettype wire

### hdl/i2a_emit.sv
// Character emitter: shifts BCD digits out MSB first, skips leading zeros,
// prefixes the sign and drives the registered result channel. Depends on i2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2a_emit
   import i2a_pkg::*;
#(
   parameter int DIGITS = dec_digits(VALUE_BITS_DEF)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire conv_ctl_type         in_ctl,
   output logic                      in_ready,
   input  wire logic [DIGITS*4-1:0]  in_bcd,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_char_code,
   output logic                      rsp_last
);

   localparam int REM_W = $clog2(DIGITS + 1);

   logic                 busy_ff, busy_in;
   logic                 sign_ff, sign_in;
   logic                 started_ff, started_in;
   logic [DIGITS*4-1:0]  digits_ff, digits_in;
   logic [REM_W-1:0]     remain_ff, remain_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic                 load;
   logic                 is_last;
   logic [3:0]           top;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      load     = in_ctl.valid && !busy_ff;
      top      = digits_ff[DIGITS*4-1 -: 4];
      is_last  = (remain_ff == REM_W'(1));

      busy_in      = busy_ff;
      sign_in      = sign_ff;
      started_in   = started_ff;
      digits_in    = digits_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;

      priority if (load) begin
         busy_in    = 1'b1;
         sign_in    = in_ctl.negative;
         started_in = 1'b0;
         digits_in  = in_bcd;
         remain_in  = REM_W'(DIGITS);
      end else if (busy_ff) begin
         priority if (sign_ff) begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CH_MINUS;
               last_in      = 1'b0;
               sign_in      = 1'b0;
            end
         end else if (started_ff || top != 4'd0 || is_last) begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CH_ZERO + {4'b0000, top};
               last_in      = is_last;
               digits_in    = {digits_ff[DIGITS*4-5:0], 4'b0000};
               remain_in    = remain_ff - REM_W'(1);
               started_in   = 1'b1;
               if (is_last) begin
                  busy_in = 1'b0;
               end
            end
         end else begin
            // leading zero: drop it without a character
            digits_in = {digits_ff[DIGITS*4-5:0], 4'b0000};
            remain_in = remain_ff - REM_W'(1);
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sign_ff      <= 1'b0;
         started_ff   <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         sign_ff      <= sign_in;
         started_ff   <= started_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff <= digits_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign in_ready      = !busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   a_minus_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && char_ff == CH_MINUS) |-> !last_ff)
      else $error("sign character flagged as last");

   a_busy_has_digits : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (remain_ff != '0))
      else $error("emitter busy with no digits left");

   a_load_sets_busy : assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && remain_ff == REM_W'(DIGITS)))
      else $error("handoff not captured");

   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !sign_ff && is_last && out_free) |=> (!busy_ff && rsp_valid_ff && last_ff))
      else $error("final digit did not close the item");
`endif

endmodule

`default_nettype wire

### hdl/int32_to_decimal_ascii_core.sv
// Flow: accept, then the bit-serial shift/add-3 loop over all VALUE_BITS input bits, then the
// handoff to the emitter, which sends any sign, skips leading zeros, registers each character.
// The converter takes no new value until the emitter has taken its result, so character output
// of the previous item overlaps the next loop, and a busy emitter holds the converter back.
// Reset: synchronous, active high, clears all control state; nothing is kept between items.
`timescale 1ns / 1ps
`default_nettype none

module int32_to_decimal_ascii_core
   import i2a_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [VALUE_BITS-1:0]  req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_char_code,
   output logic                               rsp_last
);

   localparam int DIGITS = dec_digits(VALUE_BITS);

   conv_ctl_type         conv_ctl;
   logic                 conv_ready;
   logic [DIGITS*4-1:0]  conv_bcd;

   i2a_conv #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .out_ctl   (conv_ctl),
      .out_ready (conv_ready),
      .out_bcd   (conv_bcd)
   );

   i2a_emit #(
      .DIGITS (DIGITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (conv_ctl),
      .in_ready      (conv_ready),
      .in_bcd        (conv_bcd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

### bench/tb_top.sv
// Testbench for int32_to_decimal_ascii_core: drives signed values and checks the
// decimal text that comes back, one character at a time. Depends on hdl/i2a_pkg.sv.
`timescale 1ns / 1ps

module tb_top;
   import i2a_pkg::*;

   localparam int VB = VALUE_BITS_DEF;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 260;
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   class decimal_text_scoreboard;
      text_char_type expected_chars[$];
      int errors;
      int values_seen;
      int chars_seen;

      task report(input string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      // builds the expected text of one value; the magnitude fits VB bits unsigned,
      // which also covers the most negative value
      function void expand_decimal(input logic [VB-1:0] v);
         logic [VB-1:0] mag;
         logic [3:0]    digs[$];
         logic          neg;
         neg = v[VB-1];
         mag = neg ? (~v + 1'b1) : v;
         do begin
            digs.push_front(4'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         if (neg)
            expected_chars.push_back('{code: CH_MINUS, last: 1'b0});
         for (int k = 0; k < digs.size(); k++)
            expected_chars.push_back('{code: 8'(CH_ZERO + digs[k]),
                                       last: (k == digs.size() - 1)});
      endfunction

      function void note_value(input logic [VB-1:0] v);
         values_seen++;
         expand_decimal(v);
      endfunction

      task check_char(input logic [7:0] code, input logic last);
         text_char_type want;
         chars_seen++;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected char 0x%02h last=%0b", code, last));
         end else begin
            want = expected_chars.pop_front();
            if (code !== want.code)
               report($sformatf("char_code 0x%02h, expected 0x%02h", code, want.code));
            if (last !== want.last)
               report($sformatf("last %0b, expected %0b", last, want.last));
         end
      endtask

      function int outstanding();
         return expected_chars.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [VB-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_char_code;
   logic                 rsp_last;

   decimal_text_scoreboard sb = new();

   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int stall_hold = 0;

   int32_to_decimal_ascii_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accepted items on both sides, plus the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_value(req_value);
         if (rsp_valid && rsp_ready)
            sb.check_char(rsp_char_code, rsp_last);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver: switches between always ready, coin flip, mostly stalled and long stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_hold > 0) begin
               rsp_ready  <= 1'b0;
               stall_hold <= stall_hold - 1;
            end else begin
               rsp_ready  <= 1'b1;
               stall_hold <= $urandom_range(0, 16);
            end
         end
      endcase
   end

   function automatic longint pow10(input int n);
      longint p;
      p = 1;
      for (int k = 0; k < n; k++)
         p = p * 10;
      return p;
   endfunction

   // mostly values of a random digit count, plus full-range, near powers of ten and extremes
   function automatic logic [VB-1:0] pick_value();
      int          kind;
      int          n;
      longint      lo;
      longint      hi;
      logic [VB-1:0] mag;
      logic        neg;
      kind = $urandom_range(0, 9);
      neg  = 1'($urandom_range(0, 1));
      case (kind)
         0: return $urandom;
         1: begin
            n   = $urandom_range(1, 9);
            mag = VB'(pow10(n) + $urandom_range(0, 2) - 1);
         end
         2: begin
            case ($urandom_range(0, 4))
               0: return {1'b1, {(VB-1){1'b0}}};
               1: return {1'b0, {(VB-1){1'b1}}};
               2: return '0;
               3: return '1;
               default: return {1'b1, {(VB-2){1'b0}}, 1'b1};
            endcase
         end
         default: begin
            n   = $urandom_range(1, 10);
            lo  = (n == 1) ? 0 : pow10(n - 1);
            hi  = (n == 10) ? 64'd2147483647 : pow10(n) - 1;
            mag = VB'($urandom_range(32'(hi), 32'(lo)));
         end
      endcase
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   // bursty sender; every gap waits on a clock edge, so valid is never dropped and
   // raised in the same step
   task send_item(input logic [VB-1:0] v);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(10, 40)) @(posedge clock);
         else
            repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task wait_drained();
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   logic [VB-1:0] directed_values[$] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7fffffff, 32'h80000000, 32'h80000001, 32'd1000000000,
      32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
      32'h55555555, 32'haaaaaaaa, -32'sd5, 32'd1000000, -32'sd100000
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i])
         send_item(directed_values[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            // hold off until the block has emitted everything
            req_valid <= 1'b0;
            wait_drained();
            burst_left = 0;
         end
         send_item(pick_value());
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d chars never arrived", sb.outstanding()));

      $display("Converted %0d values into %0d characters, covering zero, both extremes,",
               sb.values_seen, sb.chars_seen);
      $display("every digit count, both signs and random idling on both sides.");
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
